### hdl/obar_pkg.sv
package obar_pkg;

   localparam int SYMBOLS    = 256;
   localparam int IDX_W      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

   localparam int SYM_W      = 8;
   localparam int TIME_W     = 32;
   localparam int PRICE_W    = 48;
   localparam int STATUS_W   = 2;

   localparam int REQ_W      = 264;
   localparam int RSP_W      = 224;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SOURCE_INTERVAL = 1'd1;

   localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60;

   typedef enum logic [STATUS_W-1:0] {
      ST_MERGED  = 2'd0,
      ST_EMIT    = 2'd1,
      ST_ORDER   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] target_interval;
      logic [TIME_W-1:0] source_interval;
   } cfg_type;

   typedef struct packed {
      logic               ignore;
      logic [IDX_W-1:0]   idx;
      logic [TIME_W-1:0]  bar_time;
      logic [PRICE_W-1:0] open_price;
      logic [PRICE_W-1:0] high_price;
      logic [PRICE_W-1:0] low_price;
      logic [PRICE_W-1:0] close_price;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  last_emit_time;
      logic [TIME_W-1:0]  partial_time;
      logic [PRICE_W-1:0] partial_open;
      logic [PRICE_W-1:0] partial_high;
      logic [PRICE_W-1:0] partial_low;
      logic [PRICE_W-1:0] partial_close;
   } entry_type;

   typedef struct packed {
      status_type         status;
      logic [TIME_W-1:0]  out_time;
      logic [PRICE_W-1:0] out_open;
      logic [PRICE_W-1:0] out_high;
      logic [PRICE_W-1:0] out_low;
      logic [PRICE_W-1:0] out_close;
   } result_type;

endpackage

### hdl/ohlc_bar_aggregator.sv
// channel   dir   handshake                 payload
// req       in    req_tvalid / req_tready   req_tdata: source bar
// rsp       out   rsp_tvalid / rsp_tready   rsp_tuser: status, rsp_tdata: completed bar
// csr       in    csr_we                    csr_addr, csr_wdata
//
// Each item is read from the per-symbol memory, then merged and, unless ignored or
// out of order, written back; the next read issues only after the merge stage passes it on.
// Reset clears the seen/empty flags, queue and output; the bar memory is not cleared.
// A four-entry queue sits between intake and the merge stage; a stalled
// rsp holds the merge stage while intake keeps filling the queue.
module ohlc_bar_aggregator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // symbol_index, bar_interval, bar_time, open_price, high_price, low_price, close_price
   input  logic [obar_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_time, out_open, out_high, out_low, out_close
   output logic [obar_pkg::RSP_W-1:0]           rsp_tdata,
   // status
   output logic [obar_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic                                 csr_we,
   input  logic [obar_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [obar_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import obar_pkg::*;

   cfg_type    cfg_ff;
   logic       push_valid, push_ready;
   item_type   push_item;
   logic       pop_valid, pop_ready;
   item_type   pop_item;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_interval <= INTERVAL_RESET;
         cfg_ff.source_interval <= INTERVAL_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_TARGET_INTERVAL) begin
            cfg_ff.target_interval <= csr_wdata;
         end
         if (csr_addr == CSR_SOURCE_INTERVAL) begin
            cfg_ff.source_interval <= csr_wdata;
         end
      end
   end

   obar_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   obar_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   obar_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {result.out_close, result.out_low, result.out_high,
                       result.out_open, result.out_time};

endmodule

### hdl/obar_front.sv
module obar_front (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [obar_pkg::REQ_W-1:0] req_tdata,
   input  obar_pkg::cfg_type      cfg,
   output logic                   push_valid,
   input  logic                   push_ready,
   output obar_pkg::item_type     push_item
);
   import obar_pkg::*;

   logic [SYM_W-1:0]  symbol_index;
   logic [TIME_W-1:0] bar_interval;

   assign symbol_index = req_tdata[7:0];
   assign bar_interval = req_tdata[39:8];

   always_comb begin
      push_item.ignore      = (32'(symbol_index) >= 32'(SYMBOLS))
                              || (bar_interval != cfg.source_interval);
      push_item.idx         = IDX_W'(symbol_index);
      push_item.bar_time    = req_tdata[71:40];
      push_item.open_price  = req_tdata[119:72];
      push_item.high_price  = req_tdata[167:120];
      push_item.low_price   = req_tdata[215:168];
      push_item.close_price = req_tdata[263:216];
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

### hdl/obar_fifo.sv
module obar_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  obar_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output obar_pkg::item_type  pop_item
);
   import obar_pkg::*;

   item_type                buf_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = buf_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/obar_back.sv
module obar_back (
   input  logic                 clock,
   input  logic                 reset,
   input  obar_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  obar_pkg::item_type   pop_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output obar_pkg::result_type rsp_result
);
   import obar_pkg::*;

   entry_type          mem_ff [SYMBOLS];
   entry_type          rd_data_ff;
   logic [SYMBOLS-1:0] seen_ff, seen_in;
   logic [SYMBOLS-1:0] empty_ff, empty_in;

   logic               s2_valid_ff, s2_valid_in;
   item_type           s2_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   logic               issue, fire;
   logic               wr_en;
   entry_type          wr_data;
   result_type         res_in;
   logic [TIME_W-1:0]  elapsed;

   assign issue     = pop_valid && !s2_valid_ff;
   assign pop_ready = issue;
   assign fire      = s2_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (issue) begin
         s2_valid_in = 1'b1;
      end else if (fire) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_data  = rd_data_ff;
      seen_in  = seen_ff;
      empty_in = empty_ff;
      res_in   = '0;
      elapsed  = s2_item_ff.bar_time - rd_data_ff.last_emit_time;
      if (s2_item_ff.ignore) begin
         res_in.status = ST_IGNORED;
      end else if (!seen_ff[s2_item_ff.idx]) begin
         wr_en                          = fire;
         wr_data.last_emit_time         = s2_item_ff.bar_time;
         wr_data.partial_time           = s2_item_ff.bar_time;
         wr_data.partial_open           = s2_item_ff.open_price;
         wr_data.partial_high           = s2_item_ff.high_price;
         wr_data.partial_low            = s2_item_ff.low_price;
         wr_data.partial_close          = s2_item_ff.close_price;
         seen_in[s2_item_ff.idx]        = 1'b1;
         empty_in[s2_item_ff.idx]       = 1'b0;
         res_in.status                  = ST_MERGED;
      end else if (s2_item_ff.bar_time < rd_data_ff.last_emit_time) begin
         res_in.status = ST_ORDER;
      end else begin
         wr_en                 = fire;
         wr_data.partial_time  = s2_item_ff.bar_time;
         wr_data.partial_close = s2_item_ff.close_price;
         if (empty_ff[s2_item_ff.idx]) begin
            wr_data.partial_open = s2_item_ff.open_price;
            wr_data.partial_high = s2_item_ff.high_price;
            wr_data.partial_low  = s2_item_ff.low_price;
         end else begin
            if (s2_item_ff.low_price < rd_data_ff.partial_low) begin
               wr_data.partial_low = s2_item_ff.low_price;
            end
            if (s2_item_ff.high_price > rd_data_ff.partial_high) begin
               wr_data.partial_high = s2_item_ff.high_price;
            end
         end
         if (elapsed >= cfg.target_interval) begin
            wr_data.last_emit_time   = s2_item_ff.bar_time;
            empty_in[s2_item_ff.idx] = 1'b1;
            res_in.status            = ST_EMIT;
            res_in.out_time          = wr_data.partial_time;
            res_in.out_open          = wr_data.partial_open;
            res_in.out_high          = wr_data.partial_high;
            res_in.out_low           = wr_data.partial_low;
            res_in.out_close         = wr_data.partial_close;
         end else begin
            empty_in[s2_item_ff.idx] = 1'b0;
            res_in.status            = ST_MERGED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         empty_ff     <= '0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            seen_ff  <= seen_in;
            empty_ff <= empty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_item_ff <= pop_item;
         rd_data_ff <= mem_ff[pop_item.idx];
      end
      if (wr_en) begin
         mem_ff[s2_item_ff.idx] <= wr_data;
      end
      if (fire) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // a new result only ever comes out of the compute stage
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result without a compute stage item");

   // every taken bar marks its symbol as seen
   a_seen_set: assert property (@(posedge clock) disable iff (reset)
      fire && !s2_item_ff.ignore |=> seen_ff[$past(s2_item_ff.idx)])
      else $error("symbol not marked seen");

   // an emitted bar leaves its symbol empty
   a_empty_after_emit: assert property (@(posedge clock) disable iff (reset)
      fire && res_in.status == ST_EMIT |=> empty_ff[$past(s2_item_ff.idx)])
      else $error("partial bar not emptied after emit");

   // non-emit results carry no bar
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_EMIT |->
         rsp_ff.out_time == '0 && rsp_ff.out_open == '0 && rsp_ff.out_close == '0)
      else $error("bar fields set without emit");

endmodule
